// File: sv/pal_pkg.sv
// shared definitions for the positional array list: field widths, command and
// status codes, and the control/status structs between controller and datapath
// no dependencies
package pal_pkg;

    // field widths of one transaction
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // parameter defaults
    localparam int DEPTH_DEF = 64;
    localparam int WIDTH_DEF = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic walk;
        logic commit;
    } pal_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic do_walk;
        logic walk_done;
        logic out_free;
    } pal_sts_t;

endpackage

// File: sv/pal_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/pal_datapath.sv
// datapath of the positional array list: command registers, range checks,
// shifting walk over the element ram, count and output register
// depends on pal_pkg and pal_ram
module pal_datapath #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF,
    parameter int WIDTH = pal_pkg::WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pal_pkg::pal_cmd_t           cmd,
    output pal_pkg::pal_sts_t           sts,
    input  logic [pal_pkg::CMD_W-1:0]   in_command,
    input  logic [pal_pkg::POS_W-1:0]   in_position,
    input  logic [pal_pkg::VAL_W-1:0]   in_value,
    input  logic                        m_tready,
    output logic                        out_valid,
    output logic [pal_pkg::STAT_W-1:0]  out_status,
    output logic [pal_pkg::VAL_W-1:0]   out_value,
    output logic [pal_pkg::POS_W-1:0]   out_found,
    output logic [pal_pkg::CNT_W-1:0]   out_count,
    output logic                        out_empty
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PIW = pal_pkg::POS_W;
    localparam int PW  = (CW > PIW) ? CW : PIW;
    localparam int VW  = pal_pkg::VAL_W;
    localparam int NW  = pal_pkg::CNT_W;

    // control state
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic                       pend_reg, pend_next;
    logic                       first_reg, first_next;
    logic                       hit_reg, hit_next;
    logic                       out_valid_reg, out_valid_next;

    // payload
    logic [pal_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [PIW-1:0]             pos_reg, pos_next;
    logic [WIDTH-1:0]           val_reg, val_next;
    logic [pal_pkg::STAT_W-1:0] status_reg, status_next;
    logic [AW-1:0]              pend_addr_reg, pend_addr_next;
    logic [CW-1:0]              found_reg, found_next;
    logic [WIDTH-1:0]           vout_reg, vout_next;
    logic [pal_pkg::STAT_W-1:0] out_status_reg, out_status_next;
    logic [VW-1:0]              out_value_reg, out_value_next;
    logic [PIW-1:0]             out_found_reg, out_found_next;
    logic [NW-1:0]              out_count_reg, out_count_next;
    logic                       out_empty_reg, out_empty_next;

    // checks and ram port
    logic [PW-1:0]              pos_x, cnt_x;
    logic                       pos_zero, pos_gt_cnt, pos_gt_cnt1, is_full, is_none;
    logic [pal_pkg::STAT_W-1:0] chk_status;
    logic                       walk_op;
    logic [AW-1:0]              pos_m1;
    logic [CW-1:0]              rem_from_pos;
    logic                       issue, up;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [WIDTH-1:0]           wr_data;
    logic [WIDTH-1:0]           rd_data;
    logic [CW-1:0]              count_after;

    pal_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // range checks on the loaded command
    always_comb
    begin
        pos_x       = PW'(pos_reg);
        cnt_x       = PW'(count_reg);
        pos_zero    = (pos_reg == '0);
        pos_gt_cnt  = (pos_x > cnt_x);
        pos_gt_cnt1 = (pos_x > (cnt_x + PW'(1)));
        is_full     = (count_reg == CW'(DEPTH));
        is_none     = (count_reg == '0);
        chk_status  = pal_pkg::ST_OK;
        walk_op     = 1'b0;
        unique case (cmd_reg)
            pal_pkg::CMD_INSERT:
            begin
                walk_op = 1'b1;
                if (is_full)
                    chk_status = pal_pkg::ST_FULL;
                else if (pos_zero || pos_gt_cnt1)
                    chk_status = pal_pkg::ST_RANGE;
            end
            pal_pkg::CMD_DELETE, pal_pkg::CMD_GET:
            begin
                walk_op = 1'b1;
                if (is_none)
                    chk_status = pal_pkg::ST_EMPTY;
                else if (pos_zero || pos_gt_cnt)
                    chk_status = pal_pkg::ST_RANGE;
            end
            pal_pkg::CMD_CHANGE:
            begin
                if (pos_zero || pos_gt_cnt)
                    chk_status = pal_pkg::ST_RANGE;
            end
            pal_pkg::CMD_LOCATE:
            begin
                walk_op = 1'b1;
            end
            default:
            begin
                chk_status = pal_pkg::ST_OK;
            end
        endcase
        pos_m1       = AW'(pos_x - PW'(1));
        rem_from_pos = count_reg - CW'(pos_x) + CW'(1);
    end

    assign issue = cmd.walk && (rem_reg != '0) && !hit_reg;
    assign up    = (cmd_reg != pal_pkg::CMD_INSERT);

    assign sts.do_walk   = walk_op && (chk_status == pal_pkg::ST_OK);
    assign sts.walk_done = ((rem_reg == '0) || hit_reg) && !pend_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        pend_next       = 1'b0;
        pend_addr_next  = idx_reg;
        first_next      = first_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        vout_next       = vout_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_m1;
        wr_data         = val_reg;
        count_after     = count_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            cmd_next   = in_command;
            pos_next   = in_position;
            val_next   = WIDTH'(in_value);
            vout_next  = '0;
            found_next = '0;
        end

        // status and walk set-up
        if (cmd.check)
        begin
            status_next = chk_status;
            first_next  = 1'b1;
            hit_next    = 1'b0;
            unique case (cmd_reg)
                pal_pkg::CMD_INSERT:
                begin
                    idx_next = AW'(count_reg - CW'(1));
                    rem_next = rem_from_pos;
                end
                pal_pkg::CMD_DELETE:
                begin
                    idx_next = pos_m1;
                    rem_next = rem_from_pos;
                end
                pal_pkg::CMD_GET:
                begin
                    idx_next = pos_m1;
                    rem_next = CW'(1);
                end
                default:
                begin
                    idx_next = '0;
                    rem_next = count_reg;
                end
            endcase
        end

        // at most one read issued, the previous read consumed
        if (cmd.walk)
        begin
            pend_next = issue;
            if (issue)
            begin
                idx_next = up ? idx_reg + AW'(1) : idx_reg - AW'(1);
                rem_next = rem_reg - CW'(1);
            end
            if (pend_reg)
            begin
                first_next = 1'b0;
                unique case (cmd_reg)
                    pal_pkg::CMD_INSERT:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr_reg + AW'(1);
                        wr_data = rd_data;
                    end
                    pal_pkg::CMD_DELETE:
                    begin
                        if (first_reg)
                        begin
                            vout_next = rd_data;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pend_addr_reg - AW'(1);
                            wr_data = rd_data;
                        end
                    end
                    pal_pkg::CMD_GET:
                    begin
                        vout_next = rd_data;
                    end
                    pal_pkg::CMD_LOCATE:
                    begin
                        if (!hit_reg && (rd_data == val_reg))
                        begin
                            hit_next   = 1'b1;
                            found_next = CW'(pend_addr_reg) + CW'(1);
                        end
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
        end

        // final update and result
        if (cmd.commit)
        begin
            if (status_reg == pal_pkg::ST_OK)
            begin
                unique case (cmd_reg)
                    pal_pkg::CMD_INSERT:
                    begin
                        wr_en       = 1'b1;
                        count_after = count_reg + CW'(1);
                    end
                    pal_pkg::CMD_DELETE:
                    begin
                        count_after = count_reg - CW'(1);
                    end
                    pal_pkg::CMD_CHANGE:
                    begin
                        wr_en = 1'b1;
                    end
                    pal_pkg::CMD_CLEAR:
                    begin
                        count_after = '0;
                    end
                    default:
                    begin
                        count_after = count_reg;
                    end
                endcase
            end
            count_next      = count_after;
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_value_next  = VW'(vout_reg);
            out_found_next  = PIW'(found_reg);
            out_count_next  = NW'(count_after);
            out_empty_next  = (count_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        pend_addr_reg  <= pend_addr_next;
        found_reg      <= found_next;
        vout_reg       <= vout_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_found  = out_found_reg;
    assign out_count  = out_count_reg;
    assign out_empty  = out_empty_reg;

endmodule

// File: sv/pal_ctrl.sv
// controller of the positional array list: sequences load, check, walk and
// commit for one transaction at a time
// depends on pal_pkg
module pal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pal_pkg::pal_sts_t sts,
    output pal_pkg::pal_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.do_walk ? S_WALK : S_FINISH;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: sv/positional_array_list.sv
// positional array list top, one transaction in, one result out; built on pal_ctrl and pal_datapath
// change, clear and rejected commands skip the walk; a walk reads up to DEPTH ram entries
// throughput: one transaction at a time; the next is taken once the result sits
//   in the output register, which holds it until the sink takes it
// reset: count and all control state clear; the element ram is not cleared
module positional_array_list #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF,
    parameter int WIDTH = pal_pkg::WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command [2:0], position [9:3], value [41:10], zero pad [47:42]
    input  logic [pal_pkg::S_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], value_out [33:2], found_position [40:34], count [47:41],
    // is_empty [48], zero pad [55:49]
    output logic [pal_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int M_USED = pal_pkg::STAT_W + pal_pkg::VAL_W + pal_pkg::POS_W
                            + pal_pkg::CNT_W + 1;

    pal_pkg::pal_cmd_t            cmd;
    pal_pkg::pal_sts_t            sts;
    logic [pal_pkg::CMD_W-1:0]    in_command;
    logic [pal_pkg::POS_W-1:0]    in_position;
    logic [pal_pkg::VAL_W-1:0]    in_value;
    logic [pal_pkg::STAT_W-1:0]   out_status;
    logic [pal_pkg::VAL_W-1:0]    out_value;
    logic [pal_pkg::POS_W-1:0]    out_found;
    logic [pal_pkg::CNT_W-1:0]    out_count;
    logic                         out_empty;

    // unpack the incoming transaction, lowest field first
    assign in_command  = s_tdata[pal_pkg::CMD_W-1:0];
    assign in_position = s_tdata[pal_pkg::CMD_W +: pal_pkg::POS_W];
    assign in_value    = s_tdata[pal_pkg::CMD_W + pal_pkg::POS_W +: pal_pkg::VAL_W];

    // sequencing: idle, check, walk over the ram, commit into output register
    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // element ram, count, range checks and the result register
    pal_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_command  (in_command),
        .in_position (in_position),
        .in_value    (in_value),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_value   (out_value),
        .out_found   (out_found),
        .out_count   (out_count),
        .out_empty   (out_empty)
    );

    // pack the result, lowest field first, zero padded to whole bytes
    assign m_tdata = {{(pal_pkg::M_TDATA_W - M_USED){1'b0}},
                      out_empty, out_count, out_found, out_value, out_status};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for positional_array_list: drives list commands into the
// command stream, predicts every result with a behavioural list and checks the results
// depends on pal_pkg and positional_array_list
module testbench;
    import pal_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS = 1500;
    localparam int REPORT_LIMIT = 10;
    // drain time after the last expected result, so that a late stray result is caught
    localparam int DRAIN_CYCLES = 100;
    localparam int SINK_HOLD_CYCLES = 400;

    // same bit order as m_tdata once packed: status sits in the lowest bits
    typedef struct packed {
        logic              is_empty;
        logic [CNT_W-1:0]  count;
        logic [POS_W-1:0]  found_pos;
        logic [VAL_W-1:0]  value_out;
        logic [STAT_W-1:0] status;
    } list_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // behavioural copy of the list contents and length
    logic [VAL_W-1:0]      shadow_entries [LIST_DEPTH];
    int                    shadow_len = 0;
    // results still owed by the block, oldest first
    list_result_t          pending_results [$];
    int                    fail_count = 0;
    // idling controls shared between the test tasks and the result process
    bit                    src_steady = 1'b0;
    bit                    sink_steady = 1'b0;
    int                    sink_hold_request = 0;
    // small set of values so that locate sees repeated entries
    logic [VAL_W-1:0]      value_pool [8];

    positional_array_list #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VAL_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(20_000_000);
        $display("positional_array_list regression: fail");
        $finish;
    end

    // runs one command on the shadow list and returns the result it must produce
    function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [VAL_W-1:0] val);
        list_result_t r;
        int           p;
        int           k;
        r = '0;
        p = int'(pos);
        case (cmd)
            CMD_INSERT:
            begin
                // fullness wins over a bad position
                if (shadow_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else if (p < 1 || p > shadow_len + 1)
                    r.status = ST_RANGE;
                else
                begin
                    for (k = shadow_len; k > p - 1; k--)
                        shadow_entries[k] = shadow_entries[k - 1];
                    shadow_entries[p - 1] = val;
                    shadow_len++;
                end
            end
            CMD_DELETE:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > shadow_len)
                    r.status = ST_RANGE;
                else
                begin
                    r.value_out = shadow_entries[p - 1];
                    for (k = p - 1; k + 1 < shadow_len; k++)
                        shadow_entries[k] = shadow_entries[k + 1];
                    shadow_len--;
                end
            end
            CMD_CHANGE:
            begin
                // an empty list reports a range error here, not empty
                if (p < 1 || p > shadow_len)
                    r.status = ST_RANGE;
                else
                    shadow_entries[p - 1] = val;
            end
            CMD_GET:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > shadow_len)
                    r.status = ST_RANGE;
                else
                    r.value_out = shadow_entries[p - 1];
            end
            CMD_LOCATE:
            begin
                for (k = 0; k < shadow_len && r.found_pos == 0; k++)
                    if (shadow_entries[k] == val)
                        r.found_pos = POS_W'(k + 1);
            end
            CMD_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        r.count    = CNT_W'(shadow_len);
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected %h actual %h", name, want, got));
    endtask

    // offers one command transaction, with an optional random gap in front,
    // and records the expected result once the block takes it
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = 0;
        if (!src_steady && $urandom_range(0, 99) < 20)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // tvalid is left high after acceptance; the next call lowers it only for a gap, the end lowers it
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CMD_W - POS_W - VAL_W){1'b0}}, val, pos, cmd};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        pending_results.push_back(apply_list_command(cmd, pos, val));
    endtask

    // one random command; mode 0-1 grows the list, 2-3 shrinks it, the rest mixes
    task automatic send_random_command(input int mode);
        int               w_ins, w_del, w_chg, w_get, w_loc, w_clr;
        int               roll;
        int               limit;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        if (mode <= 1)
        begin
            w_ins = 70; w_del = 5; w_chg = 5; w_get = 8; w_loc = 10; w_clr = 1;
        end
        else if (mode <= 3)
        begin
            w_ins = 10; w_del = 55; w_chg = 5; w_get = 10; w_loc = 17; w_clr = 2;
        end
        else
        begin
            w_ins = 30; w_del = 20; w_chg = 12; w_get = 15; w_loc = 19; w_clr = 2;
        end

        roll = $urandom_range(0, 99);
        if (roll < w_ins)
            cmd = CMD_INSERT;
        else if (roll < w_ins + w_del)
            cmd = CMD_DELETE;
        else if (roll < w_ins + w_del + w_chg)
            cmd = CMD_CHANGE;
        else if (roll < w_ins + w_del + w_chg + w_get)
            cmd = CMD_GET;
        else if (roll < w_ins + w_del + w_chg + w_get + w_loc)
            cmd = CMD_LOCATE;
        else if (roll < w_ins + w_del + w_chg + w_get + w_loc + w_clr)
            cmd = CMD_CLEAR;
        else
            cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;

        // mostly legal positions, some right on the edges, some anywhere
        limit = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
        roll  = $urandom_range(0, 99);
        if (roll < 75 && limit > 0)
            pos = POS_W'($urandom_range(1, limit));
        else if (roll < 85)
        begin
            case ($urandom_range(0, 2))
                0:       pos = '0;
                1:       pos = POS_W'(limit);
                default: pos = POS_W'(limit + 1);
            endcase
        end
        else
            pos = POS_W'($urandom_range(0, 127));

        // locate mostly looks for something that is stored
        roll = $urandom_range(0, 99);
        if (shadow_len > 0 && roll < ((cmd == CMD_LOCATE) ? 60 : 20))
            val = shadow_entries[$urandom_range(0, shadow_len - 1)];
        else if (roll < 70)
            val = $urandom();
        else
            val = value_pool[$urandom_range(0, 7)];

        send_command(cmd, pos, val);
    endtask

    // every command against an empty list, plus the unused codes
    task automatic test_empty_list();
        send_command(CMD_DELETE, 7'd1, '0);
        send_command(CMD_GET, 7'd1, '0);
        send_command(CMD_CHANGE, 7'd1, 32'h1234_5678);
        send_command(CMD_LOCATE, 7'd0, '0);
        send_command(CMD_INSERT, 7'd0, 32'hffff_ffff);
        send_command(CMD_INSERT, 7'd2, 32'hffff_ffff);
        send_command(CMD_CLEAR, 7'd0, '0);
        send_command(CMD_SPARE_A, 7'd1, 32'h0000_0001);
        send_command(CMD_SPARE_B, 7'h7f, 32'hffff_ffff);
    endtask

    // value extremes, boundary positions, first-match locate and clear
    task automatic test_edge_cases();
        send_command(CMD_INSERT, 7'd1, 32'h0000_0000);
        send_command(CMD_INSERT, 7'd2, 32'hffff_ffff);
        send_command(CMD_INSERT, 7'd1, 32'ha5a5_a5a5);
        // append right after the last entry, then one past it
        send_command(CMD_INSERT, 7'd4, 32'h0000_0000);
        send_command(CMD_INSERT, 7'd6, 32'h0000_0001);
        send_command(CMD_GET, 7'd4, '0);
        send_command(CMD_GET, 7'd5, '0);
        send_command(CMD_GET, 7'd0, '0);
        send_command(CMD_CHANGE, 7'd3, 32'h5a5a_5a5a);
        send_command(CMD_CHANGE, 7'd0, 32'h5a5a_5a5a);
        // zero is stored twice: the first position must come back
        send_command(CMD_LOCATE, 7'h7f, 32'h0000_0000);
        send_command(CMD_LOCATE, 7'd0, 32'hdead_beef);
        send_command(CMD_DELETE, 7'd2, '0);
        send_command(CMD_DELETE, 7'd4, '0);
        send_command(CMD_DELETE, 7'd0, '0);
        send_command(CMD_SPARE_A, 7'd2, 32'h0000_0000);
        send_command(CMD_CLEAR, 7'd1, 32'hffff_ffff);
        send_command(CMD_GET, 7'd1, '0);
    endtask

    // fill to capacity, then exercise full-list rejects and full-length walks
    task automatic test_full_list();
        logic [VAL_W-1:0] tail_value;
        while (shadow_len < LIST_DEPTH)
            send_command(CMD_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), $urandom());
        send_command(CMD_INSERT, 7'd1, '0);
        send_command(CMD_INSERT, 7'h7f, '0);
        tail_value = shadow_entries[LIST_DEPTH - 1];
        send_command(CMD_LOCATE, 7'd0, tail_value);
        send_command(CMD_GET, POS_W'(LIST_DEPTH), '0);
        send_command(CMD_GET, POS_W'(LIST_DEPTH + 1), '0);
        send_command(CMD_CHANGE, POS_W'(LIST_DEPTH), 32'hffff_ffff);
        send_command(CMD_LOCATE, 7'd0, 32'hffff_ffff);
        send_command(CMD_DELETE, 7'd1, '0);
        send_command(CMD_INSERT, POS_W'(LIST_DEPTH), 32'h8000_0000);
        send_command(CMD_DELETE, POS_W'(LIST_DEPTH), '0);
        send_command(CMD_CLEAR, 7'd0, '0);
    endtask

    // sink holds off for a long stretch while commands keep coming, so the
    // output register fills and the command stream stalls
    task automatic test_backpressure();
        sink_hold_request = SINK_HOLD_CYCLES;
        src_steady = 1'b1;
        repeat (24) send_random_command(4);
        src_steady = 1'b0;
    endtask

    // random traffic in grow, shrink and mixed episodes, with one stretch of
    // transactions where neither side idles
    task automatic test_random_traffic();
        int done;
        int mode;
        int episode_len;
        int k;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            episode_len = $urandom_range(20, 80);
            for (k = 0; k < episode_len && done < RANDOM_ITEMS; k++)
            begin
                src_steady  = (done >= 500 && done < 800);
                sink_steady = src_steady;
                send_random_command(mode);
                done++;
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // result side: checks every accepted transaction and drives m_tready
    initial
    begin : result_monitor
        list_result_t seen;
        list_result_t want;
        int           hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                seen = m_tdata[$bits(list_result_t)-1:0];
                if (pending_results.size() == 0)
                    note_failure($sformatf("result with nothing expected: %h", m_tdata));
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(seen.status));
                    check_field("value_out", want.value_out, seen.value_out);
                    check_field("found_position", VAL_W'(want.found_pos),
                                VAL_W'(seen.found_pos));
                    check_field("count", VAL_W'(want.count), VAL_W'(seen.count));
                    check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(seen.is_empty));
                end
            end
            // a requested hold-off is counted down here, cycle by cycle
            if (sink_hold_request > 0)
            begin
                hold = sink_hold_request;
                sink_hold_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (sink_steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin : stimulus
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = 32'h0000_0001;
        value_pool[3] = 32'h8000_0000;
        value_pool[4] = 32'haaaa_aaaa;
        value_pool[5] = 32'h5555_5555;
        value_pool[6] = 32'h7fff_ffff;
        value_pool[7] = 32'h1234_5678;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edge_cases();
        test_full_list();
        test_backpressure();
        test_random_traffic();

        // last transaction was taken at this edge, nothing else drives tvalid here
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("positional_array_list regression: pass");
        else
            $display("positional_array_list regression: fail");
        $finish;
    end

endmodule
